FILE: design/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer
// transfer structs for both channels, command codes, cell constants
// no dependencies
package tcw_pkg;

  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;
  localparam int HEADER_ROWS_DEF = 3;

  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int ADDR_W  = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_FIXED  = 16'h0F20;
  localparam logic [CELL_W-1:0] BAR_CELL     = 16'h0F7C;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } tcw_cmd_e;

  typedef struct packed {
    tcw_cmd_e          cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_addr;
  } tcw_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } tcw_out_t;

  // result offered by the core to the output register
  typedef struct packed {
    logic     valid;
    tcw_out_t data;
  } tcw_res_t;

endpackage

FILE: design/tcw_ram.sv
// tcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/tcw_core.sv
// tcw_core: command sequencer, cursor and cell scan engine of the console writer
// drives the ports of the cell ram; depends on tcw_pkg
module tcw_core #(
  parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcw_pkg::ROWS_DEF,
  parameter int HEADER_ROWS = tcw_pkg::HEADER_ROWS_DEF,
  localparam int CELLS      = COLUMNS * ROWS,
  localparam int AW         = $clog2(CELLS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  tcw_pkg::tcw_in_t            in_data_i,
  output logic                        in_stall_o,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data_i,
  input  logic                        res_ready_i,
  output tcw_pkg::tcw_res_t           res_o,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]  ram_rdata_i
);

  localparam int CW           = $clog2(COLUMNS + 1);
  localparam int RW           = $clog2(ROWS + 1);
  // scroll pass starts at the header, or at the last row if the header covers all rows above it
  localparam int START_ROW    = (HEADER_ROWS < ROWS - 1) ? HEADER_ROWS : ROWS - 1;
  localparam int SCROLL_START = START_ROW * COLUMNS;
  localparam int COPY_END     = (ROWS - 1) * COLUMNS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_CLEAR  = 5'b01000,
    S_DONE   = 5'b10000
  } tcw_state_e;

  tcw_state_e                 state_q, state_d;
  logic [CW-1:0]              col_q, col_d;
  logic [RW-1:0]              row_q, row_d;
  logic [tcw_pkg::ATTR_W-1:0] attr_q, attr_d;
  logic                       run_q, run_d;
  logic                       pend_q, pend_d;
  logic [AW-1:0]              scan_addr_q, scan_addr_d;
  logic [CW-1:0]              scan_col_q, scan_col_d;
  logic [RW-1:0]              scan_row_q, scan_row_d;
  logic [AW-1:0]              pend_addr_q, pend_addr_d;
  logic                       pend_copy_q, pend_copy_d;
  logic                       pend_bar_q, pend_bar_d;
  logic [tcw_pkg::CHAR_W-1:0] char_q, char_d;
  logic [tcw_pkg::CELL_W-1:0] data_q, data_d;
  logic                       scr_q, scr_d;

  logic                       wrap;
  logic [RW-1:0]              row1;
  logic [CW-1:0]              col1;
  logic                       in_scroll;
  logic [RW-1:0]              ch_row;
  logic [CW-1:0]              ch_col;
  logic [tcw_pkg::CHAR_W-1:0] ch_code;
  logic [AW-1:0]              ch_idx;
  logic                       copy;

  // cursor after the right-edge wrap
  assign wrap = col_q >= CW'(COLUMNS);
  assign row1 = wrap ? row_q + RW'(1) : row_q;
  assign col1 = wrap ? '0 : col_q;

  // character unit: at accept, or at the end of a scroll on the last row
  assign in_scroll = state_q == S_SCROLL;
  assign ch_row    = in_scroll ? RW'(ROWS - 1) : row1;
  assign ch_col    = in_scroll ? '0 : col1;
  assign ch_code   = in_scroll ? char_q : in_data_i.char_code;
  assign ch_idx    = AW'(int'(ch_row) * COLUMNS + int'(ch_col));

  assign copy = in_scroll && (scan_addr_q < AW'(COPY_END));

  assign in_stall_o        = state_q != S_IDLE;
  assign res_o.valid       = state_q == S_DONE;
  assign res_o.data.cursor_pos =
    tcw_pkg::POS_W'(int'(row_q) * COLUMNS + int'(col_q));
  assign res_o.data.cell_data  = data_q;
  assign res_o.data.scrolled   = scr_q;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    attr_d      = cfg_we_i ? cfg_data_i : attr_q;
    run_d       = run_q;
    pend_d      = 1'b0;
    scan_addr_d = scan_addr_q;
    scan_col_d  = scan_col_q;
    scan_row_d  = scan_row_q;
    pend_addr_d = pend_addr_q;
    pend_copy_d = pend_copy_q;
    pend_bar_d  = pend_bar_q;
    char_d      = char_q;
    data_d      = data_q;
    scr_d       = scr_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    // write stage of the scan, in the cycle after the read
    ram_we_o    = pend_q;
    ram_waddr_o = pend_addr_q;
    if (pend_bar_q) begin
      ram_wdata_o = tcw_pkg::BAR_CELL;
    end else if (pend_copy_q) begin
      ram_wdata_o = ram_rdata_i;
    end else if (in_scroll) begin
      ram_wdata_o = tcw_pkg::BLANK_FIXED;
    end else begin
      ram_wdata_o = {attr_q, tcw_pkg::CHAR_SPACE};
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          data_d = '0;
          scr_d  = 1'b0;
          unique case (in_data_i.cmd)
            tcw_pkg::CMD_PUT: begin
              if (row1 >= RW'(ROWS)) begin
                char_d      = in_data_i.char_code;
                scan_addr_d = AW'(SCROLL_START);
                scan_col_d  = '0;
                scan_row_d  = RW'(START_ROW);
                run_d       = 1'b1;
                state_d     = S_SCROLL;
              end else begin
                if (ch_code == tcw_pkg::CHAR_NEWLINE) begin
                  row_d = ch_row + RW'(1);
                  col_d = '0;
                end else begin
                  ram_we_o    = 1'b1;
                  ram_waddr_o = ch_idx;
                  ram_wdata_o = {attr_q, ch_code};
                  row_d       = ch_row;
                  col_d       = ch_col + CW'(1);
                end
                state_d = S_DONE;
              end
            end
            tcw_pkg::CMD_READ: begin
              if (int'(in_data_i.cell_addr) < CELLS) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = AW'(in_data_i.cell_addr);
                state_d     = S_READ;
              end else begin
                state_d = S_DONE;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              col_d       = '0;
              row_d       = '0;
              scan_addr_d = '0;
              scan_col_d  = '0;
              scan_row_d  = '0;
              run_d       = 1'b1;
              state_d     = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        data_d  = ram_rdata_i;
        state_d = S_DONE;
      end
      S_SCROLL, S_CLEAR: begin
        if (run_q) begin
          pend_d      = 1'b1;
          pend_addr_d = scan_addr_q;
          pend_copy_d = copy;
          pend_bar_d  = (scan_col_q == CW'(COLUMNS - 1)) &&
                        (int'(scan_row_q) >= HEADER_ROWS);
          if (copy) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = scan_addr_q + AW'(COLUMNS);
          end
          if (scan_addr_q == AW'(CELLS - 1)) begin
            run_d = 1'b0;
          end else begin
            scan_addr_d = scan_addr_q + AW'(1);
          end
          if (scan_col_q == CW'(COLUMNS - 1)) begin
            scan_col_d = '0;
            scan_row_d = scan_row_q + RW'(1);
          end else begin
            scan_col_d = scan_col_q + CW'(1);
          end
        end else if (!pend_q) begin
          // pass drained, write port is free
          if (in_scroll) begin
            scr_d = 1'b1;
            if (ch_code == tcw_pkg::CHAR_NEWLINE) begin
              row_d = ch_row + RW'(1);
              col_d = '0;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = ch_idx;
              ram_wdata_o = {attr_q, ch_code};
              row_d       = ch_row;
              col_d       = ch_col + CW'(1);
            end
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      attr_q  <= tcw_pkg::ATTR_RESET;
      run_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      attr_q  <= attr_d;
      run_q   <= run_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_addr_q <= scan_addr_d;
    scan_col_q  <= scan_col_d;
    scan_row_q  <= scan_row_d;
    pend_addr_q <= pend_addr_d;
    pend_copy_q <= pend_copy_d;
    pend_bar_q  <= pend_bar_d;
    char_q      <= char_d;
    data_q      <= data_d;
    scr_q       <= scr_d;
  end

endmodule

FILE: design/text_console_writer.sv
// text_console_writer: text console with cursor, wrap, scroll, cell read and clear
// top level; depends on tcw_pkg, tcw_core and tcw_ram
//
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  in_data_i   (tcw_in_t)
// out      output     out_valid_o/out_stall_i out_data_o (tcw_out_t)
// cfg      input      cfg_we_i               cfg_data_i  (text attribute)
//
// plain put: one ram write (none for a newline), no read
// read: one registered ram read, none for an address past the screen
// clear: one cell per cycle through the single write port
// put that scrolls: a pipelined read-then-write sweep over the scrolled area
//   on the ram ports
// reset clears cursor and control only; cell contents are undefined until a clear
// an output register holds a finished result, so the next transfer can be taken
//   while the downstream side stalls
module text_console_writer #(
  parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcw_pkg::ROWS_DEF,
  parameter int HEADER_ROWS = tcw_pkg::HEADER_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcw_pkg::tcw_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcw_pkg::tcw_out_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data_i
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tcw_pkg::tcw_res_t          res;
  logic                       res_ready;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic                       out_valid_q, out_valid_d;
  tcw_pkg::tcw_out_t          out_data_q, out_data_d;

  // core may hand over a result when the output register is empty or draining
  assign res_ready = !out_valid_q || !out_stall_i;

  tcw_core #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .HEADER_ROWS (HEADER_ROWS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // cell store, attribute in the high byte, character in the low byte
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: load on a handover, drop once the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res.data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // one item at a time: after a transfer in, the input side is busy
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o
  ) else $error("input taken while an item is still at work");

  // no result pending in the core while it takes new input
  a_no_result_when_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res.valid
  ) else $error("core idle with a result still pending");

  // cursor never goes past one beyond the last cell
  a_cursor_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_data_o.cursor_pos) <= CELLS
  ) else $error("cursor position out of range");

endmodule

FILE: tb/tb_text_console_writer.sv
// tb_text_console_writer: self-checking testbench for the text console writer
// drives put, read, clear and unused commands with random pacing, mirrors the
// screen and cursor in a local model; depends on tcw_pkg and text_console_writer
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int HEADER_ROWS = HEADER_ROWS_DEF;
  localparam int CELLS       = COLUMNS * ROWS;

  // total input transfers to send before the run winds down
  localparam int ITEM_TARGET = 1950;
  // worst case is a clear on every transfer plus the longest stall and gap,
  // taken about five times over
  localparam longint LIMIT_CYCLES = 20_000_000;
  // cycles to keep watching the output once nothing is awaited
  localparam int TAIL_CYCLES = 12;

  // command code that the block must ignore
  localparam tcw_cmd_e CMD_RESERVED = tcw_cmd_e'(2'd3);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i;
  logic              in_stall_o;
  tcw_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  tcw_out_t          out_data_o;
  logic              cfg_we_i;
  logic [ATTR_W-1:0] cfg_data_i;

  // mirror of the screen contents, the cursor and the attribute register
  logic [CELL_W-1:0] cell_mirror [CELLS];
  int                mirror_col;
  int                mirror_row;
  logic [ATTR_W-1:0] mirror_attr;
  bit                screen_cleared;

  // results predicted for accepted transfers, oldest first
  tcw_out_t          awaited_results [$];
  tcw_out_t          oldest_result;

  int                mismatch_count;
  int                sent_count;
  int                put_count;
  int                read_count;
  int                clear_count;
  int                scroll_count;
  int                attr_writes;
  longint            cycle_count;

  // sender pacing
  bit                gaps_enabled;
  int                burst_left;

  // receiver stall pattern
  int                stall_left;
  int                flow_left;

  text_console_writer #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .HEADER_ROWS(HEADER_ROWS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // screen mirror
  // ---------------------------------------------------------------------------

  // right-edge bar below the header, fixed attribute
  function automatic void draw_mirror_bars();
    for (int r = HEADER_ROWS; r < ROWS; r++) begin
      cell_mirror[r * COLUMNS + (COLUMNS - 1)] = BAR_CELL;
    end
  endfunction

  // apply one accepted transfer to the mirror and work out its result
  function automatic tcw_out_t advance_console(input tcw_in_t item);
    tcw_out_t res;
    res = '0;
    case (item.cmd)
      CMD_PUT: begin
        put_count++;
        // past the right edge: wrap to the next row
        if (mirror_col >= COLUMNS) begin
          mirror_row++;
          mirror_col = 0;
        end
        // past the bottom: rows below the header move up, last row goes blank
        if (mirror_row >= ROWS) begin
          if (HEADER_ROWS + 1 < ROWS) begin
            for (int i = HEADER_ROWS * COLUMNS; i < (ROWS - 1) * COLUMNS; i++) begin
              cell_mirror[i] = cell_mirror[i + COLUMNS];
            end
          end
          // the blank fill uses the fixed attribute, not the register
          for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
            cell_mirror[i] = BLANK_FIXED;
          end
          draw_mirror_bars();
          mirror_row   = ROWS - 1;
          mirror_col   = 0;
          res.scrolled = 1'b1;
          scroll_count++;
        end
        if (item.char_code == CHAR_NEWLINE) begin
          mirror_row++;
          mirror_col = 0;
        end else begin
          cell_mirror[mirror_row * COLUMNS + mirror_col] = {mirror_attr, item.char_code};
          mirror_col++;
        end
      end
      CMD_READ: begin
        read_count++;
        // addresses past the screen read as zero
        if (item.cell_addr < CELLS) begin
          res.cell_data = cell_mirror[item.cell_addr];
        end
      end
      CMD_CLEAR: begin
        clear_count++;
        for (int i = 0; i < CELLS; i++) begin
          cell_mirror[i] = {mirror_attr, CHAR_SPACE};
        end
        draw_mirror_bars();
        mirror_col     = 0;
        mirror_row     = 0;
        screen_cleared = 1'b1;
      end
      default: begin
        // unused code: nothing changes
      end
    endcase
    res.cursor_pos = POS_W'(mirror_row * COLUMNS + mirror_col);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // hold the input channel idle for a number of cycles
  task automatic idle_cycles(input int count);
    repeat (count) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // offer one transfer and wait until the block takes it
  task automatic send_item(input tcw_cmd_e cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] addr);
    tcw_in_t item;
    item.cmd       = cmd;
    item.char_code = ch;
    item.cell_addr = addr;
    // bursts of random length separated by random gaps
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    // stall is sampled as it stood before the edge
    do @(posedge clk_i); while (in_stall_o);
    awaited_results.push_back(advance_console(item));
    sent_count++;
  endtask

  // stop sending and let every awaited result come back
  task automatic wait_idle();
    idle_cycles(1);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // attribute register write; only called with the block idle
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    mirror_attr = value;
    attr_writes++;
  endtask

  // run of random characters; newlines optionally replaced by spaces
  task automatic put_text(input int count, input bit allow_newline);
    logic [CHAR_W-1:0] ch;
    repeat (count) begin
      ch = CHAR_W'($urandom_range(0, 255));
      if (!allow_newline && ch == CHAR_NEWLINE) ch = CHAR_SPACE;
      send_item(CMD_PUT, ch, ADDR_W'($urandom));
    end
  endtask

  // read address: mostly on screen, often near the bottom, sometimes past the end
  function automatic logic [ADDR_W-1:0] pick_read_addr();
    case ($urandom_range(0, 7))
      0:       return ADDR_W'($urandom_range(CELLS, (1 << ADDR_W) - 1));
      1, 2, 3: return ADDR_W'($urandom_range((ROWS - 2) * COLUMNS, CELLS - 1));
      default: return ADDR_W'($urandom_range(0, CELLS - 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  // stall pattern: short stalls between flow runs of random length, with
  // the occasional long run free of stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (flow_left > 0) begin
      flow_left--;
      out_stall_i <= 1'b0;
    end else begin
      stall_left = $urandom_range(1, 8);
      flow_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(0, 12);
      out_stall_i <= 1'b0;
    end
  end

  // compare every output transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with none awaited: cursor_pos %0d cell_data %h scrolled %0b",
               out_data_o.cursor_pos, out_data_o.cell_data, out_data_o.scrolled);
        mismatch_count++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (out_data_o.cursor_pos !== oldest_result.cursor_pos) begin
          $error("cursor_pos: expected %0d, actual %0d",
                 oldest_result.cursor_pos, out_data_o.cursor_pos);
          mismatch_count++;
        end
        if (out_data_o.cell_data !== oldest_result.cell_data) begin
          $error("cell_data: expected %h, actual %h",
                 oldest_result.cell_data, out_data_o.cell_data);
          mismatch_count++;
        end
        if (out_data_o.scrolled !== oldest_result.scrolled) begin
          $error("scrolled: expected %0b, actual %0b",
                 oldest_result.scrolled, out_data_o.scrolled);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_count, awaited_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // unused command and plain puts straight after reset, before any clear
  task automatic test_unused_and_home();
    send_item(CMD_RESERVED, '0, '0);
    send_item(CMD_PUT, 8'h41, '0);
    send_item(CMD_PUT, CHAR_NEWLINE, '0);
    send_item(CMD_RESERVED, '1, '1);
  endtask

  // clear, then read blanks, bars and out-of-range cells; character extremes
  task automatic test_clear_and_read();
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_READ, '0, ADDR_W'(0));
    send_item(CMD_READ, '0, ADDR_W'(COLUMNS - 1));
    send_item(CMD_READ, '0, ADDR_W'(HEADER_ROWS * COLUMNS + COLUMNS - 1));
    send_item(CMD_READ, '0, ADDR_W'(CELLS - 1));
    send_item(CMD_READ, '0, ADDR_W'(CELLS));
    send_item(CMD_READ, '1, '1);
    send_item(CMD_PUT, 8'h00, '0);
    send_item(CMD_PUT, 8'hFF, '1);
    send_item(CMD_PUT, 8'h7E, '0);
    send_item(CMD_READ, '0, ADDR_W'(0));
    send_item(CMD_READ, '0, ADDR_W'(1));
    send_item(CMD_READ, '0, ADDR_W'(2));
  endtask

  // attribute at both extremes: clear fill and written cells take it
  task automatic test_attribute_extremes();
    logic [ATTR_W-1:0] extremes [2];
    extremes[0] = '0;
    extremes[1] = '1;
    foreach (extremes[k]) begin
      wait_idle();
      write_attribute(extremes[k]);
      send_item(CMD_CLEAR, '0, '0);
      put_text(1, 1'b0);
      send_item(CMD_READ, '0, ADDR_W'(0));
      send_item(CMD_READ, '0, ADDR_W'(COLUMNS));
      send_item(CMD_READ, '0, ADDR_W'(CELLS - 1));
    end
  endtask

  // a full row, then a put past the right edge; also a newline at the edge
  task automatic test_line_wrap();
    wait_idle();
    write_attribute(8'h3C);
    send_item(CMD_CLEAR, '0, '0);
    put_text(COLUMNS, 1'b0);
    put_text(1, 1'b0);
    send_item(CMD_READ, '0, ADDR_W'(COLUMNS - 1));
    send_item(CMD_READ, '0, ADDR_W'(COLUMNS));
    put_text(COLUMNS - 1, 1'b0);
    send_item(CMD_PUT, CHAR_NEWLINE, '0);
    send_item(CMD_READ, '0, ADDR_W'(2 * COLUMNS));
  endtask

  // reach the bottom and scroll by a put after a newline, by a full last row, and by a
  // newline while already past the bottom
  task automatic test_scroll();
    wait_idle();
    write_attribute(8'hA5);
    send_item(CMD_CLEAR, '0, '0);
    // give every row some text so the moved rows are distinguishable
    for (int r = 0; r < ROWS; r++) begin
      put_text($urandom_range(1, 6), 1'b0);
      send_item(CMD_PUT, CHAR_NEWLINE, '0);
    end
    put_text(3, 1'b0);
    send_item(CMD_READ, '0, ADDR_W'((HEADER_ROWS - 1) * COLUMNS));
    send_item(CMD_READ, '0, ADDR_W'(HEADER_ROWS * COLUMNS));
    send_item(CMD_READ, '0, ADDR_W'((ROWS - 1) * COLUMNS + 1));
    send_item(CMD_READ, '0, ADDR_W'((ROWS - 1) * COLUMNS + 5));
    // fill the last row to the edge, the next put scrolls
    put_text(COLUMNS - 3, 1'b0);
    put_text(2, 1'b0);
    // park past the bottom, then a newline scrolls and parks again
    send_item(CMD_PUT, CHAR_NEWLINE, '0);
    send_item(CMD_PUT, CHAR_NEWLINE, '0);
    send_item(CMD_READ, '0, ADDR_W'(CELLS - 1));
    send_item(CMD_READ, '0, ADDR_W'(CELLS - 2));
  endtask

  // random text in phases, each phase with its own attribute and pacing
  task automatic test_random_text();
    int next_phase_at;
    int pick;
    int len;
    next_phase_at = sent_count;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= next_phase_at) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0:       write_attribute('0);
          1:       write_attribute('1);
          default: write_attribute(ATTR_W'($urandom_range(0, 255)));
        endcase
        gaps_enabled  = ($urandom_range(0, 3) != 0);
        next_phase_at = sent_count + $urandom_range(150, 350);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // a line of text, now and then long enough to wrap
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(COLUMNS - 2, 2 * COLUMNS + 10)
                                          : $urandom_range(0, 30);
        put_text(len, 1'b1);
        if ($urandom_range(0, 6) != 0) send_item(CMD_PUT, CHAR_NEWLINE, ADDR_W'($urandom));
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 4)) send_item(CMD_READ, CHAR_W'($urandom), pick_read_addr());
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 5)) send_item(CMD_PUT, CHAR_NEWLINE, ADDR_W'($urandom));
      end else if (pick < 98) begin
        send_item(CMD_RESERVED, CHAR_W'($urandom), ADDR_W'($urandom));
      end else if (pick < 99 || !screen_cleared) begin
        send_item(CMD_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom));
      end else begin
        send_item(CMD_READ, '0, ADDR_W'($urandom_range(0, CELLS - 1)));
      end
    end
  endtask

  initial begin
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = '0;
    mirror_col     = 0;
    mirror_row     = 0;
    mirror_attr    = ATTR_RESET;
    screen_cleared = 1'b0;
    gaps_enabled   = 1'b0;
    burst_left     = 0;
    stall_left     = 0;
    flow_left      = 0;
    mismatch_count = 0;
    sent_count     = 0;
    put_count      = 0;
    read_count     = 0;
    clear_count    = 0;
    scroll_count   = 0;
    attr_writes    = 0;
    cycle_count    = 0;
    foreach (cell_mirror[i]) cell_mirror[i] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unused_and_home();
    test_clear_and_read();
    test_attribute_extremes();
    test_line_wrap();
    test_scroll();
    test_random_text();

    // drain, then watch for stray transfers
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d transfers: %0d puts with %0d scrolls, %0d reads, %0d clears",
             sent_count, put_count, scroll_count, read_count, clear_count);
    $display("%0d attribute writes over %0d cycles, %0d mismatches",
             attr_writes, cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_core.sv
design/text_console_writer.sv
tb/tb_text_console_writer.sv
